@@ src/crbe_pkg.sv @@
package crbe_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam int unsigned OUT_W = 17;
  localparam logic [16:0] OUT_ONE = 17'h10000;
  localparam logic [63:0] ABS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned QUOT_STEPS = 16;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

@@ src/crbe_if.sv @@
interface crbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  col_index;
  logic signed [31:0] value;
  modport source (output valid, opcode, col_index, value, input ready);
  modport sink (input valid, opcode, col_index, value, output ready);
endinterface

interface crbe_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] row_error;
  modport source (output valid, row_error, input ready);
  modport sink (input valid, row_error, output ready);
endinterface

@@ src/csr_row_backward_error.sv @@
// Channel | Direction | Payload
// in_ch   | sink      | opcode, col_index, value
// out_ch  | source    | row_error
// Loads and nonzeros stream back to back while no close holds off the input.
// A close row reaches the divider through the s1_close and s2_close registers;
// sixteen radix-2 steps and the S_DONE state follow, then row_error is registered.
// A zero denominator, or one not above the numerator, skips the steps.
// Input is held off while a close is in flight or its result is pending.
// Reset is synchronous; x store contents are not cleared.
module csr_row_backward_error #(
  parameter int X_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  crbe_in_if.sink    in_ch,
  crbe_out_if.source out_ch
);
  import crbe_pkg::*;

  logic fire;
  logic close_go;
  div_req_t req;
  logic div_done;
  logic [16:0] quot;
  logic out_valid;
  logic [16:0] out_data;
  logic closing;

  assign fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !closing;

  crbe_accum #(.X_DEPTH(X_DEPTH), .FRAC_BITS(FRAC_BITS)) u_accum (
    .clk, .rst, .fire,
    .opcode(in_ch.opcode), .col_index(in_ch.col_index), .value(in_ch.value),
    .close_go, .close_req(req)
  );

  crbe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .start(close_go), .req,
    .done(div_done), .quot
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      closing <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire && in_ch.opcode == OP_CLOSE) closing <= 1'b1;
      if (div_done) begin
        out_valid <= 1'b1;
        out_data <= quot;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
        closing <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.row_error = out_data;
endmodule

@@ src/crbe_div.sv @@
module crbe_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  crbe_pkg::div_req_t req,
  output logic done,
  output logic [16:0] quot
);
  import crbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  logic [63:0] rem;
  logic [63:0] den;
  logic [16:0] q;
  logic [4:0]  cnt;
  logic [64:0] shifted;
  logic        take;
  logic [63:0] zq;

  assign shifted = {rem, 1'b0};
  assign take = shifted[64] || (shifted[63:0] >= den);

  // Numerator in FRAC_BITS format to Q1.16 when the denominator is zero.
  always_comb begin
    zq = '0;
    if (FRAC_BITS >= 16) begin
      zq = req.num >> (FRAC_BITS - 16);
    end else if (req.num > (64'(OUT_ONE) >> (16 - FRAC_BITS))) begin
      zq = 64'(OUT_ONE);
    end else begin
      zq = req.num << (16 - FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rem <= req.num;
            den <= req.den;
            cnt <= '0;
            q <= '0;
            if (req.den == '0) begin
              q <= (zq > 64'(OUT_ONE)) ? OUT_ONE : zq[16:0];
              state <= S_DONE;
            end else if (req.num >= req.den) begin
              q <= OUT_ONE;
              state <= S_DONE;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rem <= take ? (shifted[63:0] - den) : shifted[63:0];
          q <= {q[15:0], take};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QUOT_STEPS - 1)) state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done = (state == S_DONE);
  assign quot = q;
endmodule

@@ src/crbe_accum.sv @@
module crbe_accum #(
  parameter int X_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  logic [1:0] opcode,
  input  logic [9:0] col_index,
  input  logic signed [31:0] value,
  output logic close_go,
  output crbe_pkg::div_req_t close_req
);
  import crbe_pkg::*;

  localparam int AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;

  logic [31:0] mem [X_DEPTH];
  logic [31:0] x_rd;
  logic        in_range;
  logic [AW-1:0] addr;

  // Stage 1: memory read. Stage 2: multiply. Stage 3: accumulate.
  logic        s1_acc;
  logic        s1_zero;
  logic [31:0] s1_a;
  logic        s2_acc;
  logic [63:0] s2_prod;
  logic        s2_neg;
  logic        s1_close;
  logic        s2_close;
  logic [31:0] s1_b;
  logic [31:0] s2_b;

  logic signed [63:0] ssum;
  logic [63:0] asum;

  logic [31:0] xv;
  logic [31:0] amag;
  logic [31:0] xmag;
  logic [63:0] m;
  logic [64:0] asum_add;
  logic signed [64:0] ssum_new;
  logic signed [64:0] bext;
  logic signed [64:0] diff;
  logic [31:0] bmag;

  assign in_range = (32'(col_index) < 32'(X_DEPTH));
  assign addr = AW'(col_index);

  always_ff @(posedge clk) begin
    if (fire && opcode == OP_LOAD && in_range) mem[addr] <= value;
    x_rd <= mem[addr];
  end

  assign xv = s1_zero ? 32'd0 : x_rd;
  assign amag = s1_a[31] ? (32'd0 - s1_a) : s1_a;
  assign xmag = xv[31] ? (32'd0 - xv) : xv;

  assign m = s2_prod >> FRAC_BITS;
  assign asum_add = {1'b0, asum} + {1'b0, m};
  assign ssum_new = s2_neg ? (65'(ssum) - 65'(signed'({1'b0, m})))
                           : (65'(ssum) + 65'(signed'({1'b0, m})));

  assign bext = 65'(signed'(s2_b));
  assign diff = bext - 65'(ssum);
  assign bmag = s2_b[31] ? (32'd0 - s2_b) : s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_acc <= 1'b0;
      s2_acc <= 1'b0;
      s1_close <= 1'b0;
      s2_close <= 1'b0;
      ssum <= '0;
      asum <= '0;
    end else begin
      s1_acc <= fire && opcode == OP_ACCUM;
      s1_close <= fire && opcode == OP_CLOSE;
      s2_acc <= s1_acc;
      s2_close <= s1_close;
      if (s2_acc) begin
        asum <= (asum_add > 65'(ABS_CAP)) ? ABS_CAP : asum_add[63:0];
        if (ssum_new > 65'sh0_7FFF_FFFF_FFFF_FFFF) ssum <= 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (ssum_new < -65'sh0_8000_0000_0000_0000) ssum <= 64'sh8000_0000_0000_0000;
        else ssum <= ssum_new[63:0];
      end
      if (s2_close) begin
        ssum <= '0;
        asum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_a <= value;
    s1_b <= value;
    s1_zero <= !in_range;
    s2_b <= s1_b;
    s2_prod <= 64'(amag) * 64'(xmag);
    s2_neg <= (s1_a[31] != xv[31]) && (amag != 0) && (xmag != 0);
  end

  assign close_go = s2_close;
  assign close_req.num = diff[64] ? 64'(-diff) : diff[63:0];
  assign close_req.den = asum + 64'(bmag);
endmodule

@@ src/crbe_checker.sv @@
module crbe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [1:0] opcode,
  input logic out_valid,
  input logic out_ready,
  input logic [16:0] row_error
);
  import crbe_pkg::*;

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_error <= OUT_ONE) else $error("row_error above one");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_error))
    else $error("result dropped");
  a_no_out_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_CLOSE |=> !out_valid) else $error("early result");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
endmodule

bind csr_row_backward_error crbe_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.opcode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .row_error(out_ch.row_error)
);

@@ verif/tb_csr_row_backward_error.sv @@
`timescale 1ns / 100ps

module tb_csr_row_backward_error;
  import crbe_pkg::*;

  logic clk;
  logic rst;

  crbe_in_if  in_ch ();
  crbe_out_if out_ch ();

  csr_row_backward_error u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Model state of the block.
  logic signed [31:0] x_mirror [0:1023];
  bit                 x_written [0:1023];
  logic signed [63:0] row_sum;
  logic [63:0]        row_abs_sum;

  logic [16:0] expected_errors [$];
  int          error_count;
  int          idle_cycles;
  int          items_sent;
  int          rows_closed;
  bit          bursts_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // floor(num * 2^16 / den) with saturation at 1.0.
  function automatic logic [16:0] quotient_q16(input logic [63:0] num,
                                                input logic [63:0] den);
    logic [64:0] rem;
    logic [16:0] q;
    if (num >= den) return OUT_ONE;
    rem = {1'b0, num};
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return (q > OUT_ONE) ? OUT_ONE : q;
  endfunction

  task automatic predict_error(input logic [1:0] op, input logic [9:0] col,
                               input logic signed [31:0] val);
    logic signed [63:0] xv;
    logic signed [63:0] bv;
    logic [63:0] prod;
    logic [63:0] num;
    logic [63:0] den;
    logic signed [64:0] wide;
    bit neg;
    case (op)
      OP_LOAD: begin
        x_mirror[col] = val;
        x_written[col] = 1'b1;
      end
      OP_ACCUM: begin
        xv = x_mirror[col];
        bv = val;
        prod = (magnitude(bv) * magnitude(xv)) >> 16;
        neg = (bv < 0) != (xv < 0);
        wide = neg ? ($signed({row_sum[63], row_sum}) - $signed({1'b0, prod}))
                   : ($signed({row_sum[63], row_sum}) + $signed({1'b0, prod}));
        if (wide > $signed(65'sh0_7FFF_FFFF_FFFF_FFFF))
          row_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (wide < $signed(65'sh1_8000_0000_0000_0000))
          row_sum = 64'sh8000_0000_0000_0000;
        else
          row_sum = wide[63:0];
        if (row_abs_sum > ABS_CAP - prod) row_abs_sum = ABS_CAP;
        else row_abs_sum = row_abs_sum + prod;
      end
      OP_CLOSE: begin
        bv = val;
        num = (bv >= row_sum) ? 64'(bv - row_sum) : 64'(row_sum - bv);
        den = row_abs_sum + magnitude(bv);
        if (den != 0) expected_errors.push_back(quotient_q16(num, den));
        else expected_errors.push_back((num > 64'(OUT_ONE)) ? OUT_ONE : num[16:0]);
        row_sum = '0;
        row_abs_sum = '0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Drives one item and waits for its transfer. The item stays on the bus
  // until the caller drives the next one or drops valid.
  task automatic send_item(input logic [1:0] op, input logic [9:0] col,
                           input logic signed [31:0] val);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.col_index <= col;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_error(op, col, val);
    items_sent++;
    if (op == OP_CLOSE) rows_closed++;
    @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_errors.size() == 0)
        report_mismatch($sformatf("unexpected row_error %0d", out_ch.row_error));
      else if (out_ch.row_error !== expected_errors[0]) begin
        report_mismatch($sformatf("row_error got %0d expected %0d",
                                  out_ch.row_error, expected_errors[0]));
        void'(expected_errors.pop_front());
      end else
        void'(expected_errors.pop_front());
    end
  end

  // Output stall bursts.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (bursts_on) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("Watchdog timeout");
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [9:0] written_col();
    logic [9:0] c;
    do c = $urandom_range(0, 1023); while (!x_written[c]);
    return c;
  endfunction

  task automatic test_load_vector();
    for (int i = 0; i < 1024; i++) begin
      x_mirror[i] = '0;
      x_written[i] = 1'b0;
    end
    // Extremes first, then every seventh entry from 4 on with random content.
    send_item(OP_LOAD, 10'd0, 32'sh7FFF_FFFF);
    send_item(OP_LOAD, 10'd1023, 32'sh8000_0000);
    send_item(OP_LOAD, 10'd1, 32'sh0001_0000);
    send_item(OP_LOAD, 10'd2, 32'sh0000_0000);
    send_item(OP_LOAD, 10'd3, -32'sh0001_0000);
    for (int i = 4; i < 1023; i += 7) send_item(OP_LOAD, 10'(i), random_value());
  endtask

  task automatic test_directed_rows();
    send_item(OP_CLOSE, 10'd0, 32'sh0);                 // zero denominator
    send_item(OP_CLOSE, 10'h3FF, 32'sh7FFF_FFFF);        // numerator equals denominator
    send_item(OP_CLOSE, 10'd0, 32'sh0000_8000);          // empty row, rhs alone
    send_item(OP_ACCUM, 10'd0, 32'sh7FFF_FFFF);
    send_item(OP_ACCUM, 10'd1023, 32'sh8000_0000);
    send_item(OP_CLOSE, 10'd5, 32'sh8000_0000);
    // Repeated largest products drive both sums far from zero.
    for (int i = 0; i < 6; i++) send_item(OP_ACCUM, 10'd1023, 32'sh8000_0000);
    send_item(OP_CLOSE, 10'd0, 32'sh0000_0001);
    for (int i = 0; i < 6; i++) send_item(OP_ACCUM, 10'd0, 32'sh8000_0000);
    send_item(OP_CLOSE, 10'd0, -32'sh1);
    send_item(OP_ACCUM, 10'd1, 32'sh0002_0000);
    send_item(OP_NONE, 10'd1, 32'sh1234_5678);           // unused opcode is ignored
    send_item(OP_CLOSE, 10'd0, 32'sh0001_0000);
  endtask

  task automatic test_random_rows(input int n_items);
    int sent;
    int nnz;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(OP_LOAD, 10'($urandom_range(0, 1023)), random_value());
        sent++;
      end else if ($urandom_range(0, 29) == 0) begin
        send_item(OP_NONE, 10'($urandom), $signed($urandom));
      end
      nnz = $urandom_range(0, 8);
      for (int k = 0; k < nnz; k++) send_item(OP_ACCUM, written_col(), random_value());
      send_item(OP_CLOSE, 10'($urandom), random_value());
      sent += nnz + 1;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.col_index = '0;
    in_ch.value = '0;
    row_sum = '0;
    row_abs_sum = '0;
    error_count = 0;
    items_sent = 0;
    rows_closed = 0;
    bursts_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_load_vector();
    test_directed_rows();
    test_random_rows(450);
    bursts_on = 1'b0;
    test_random_rows(120);
    in_ch.valid <= 1'b0;

    while (expected_errors.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items through loads, nonzeros and %0d row closes,", items_sent,
             rows_closed);
    $display("with extreme values, zero-denominator and ignored-opcode cases included.");
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
